>>> hdl/cpr_pkg.sv
// Shared types and constants for the clock page replacement block.
// Used by cpr_cell, cpr_ctrl and clock_page_replacement; depends on nothing.
package cpr_pkg;

    // Default build sizes.
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    // Fixed port widths.
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;
    localparam int COUNT_W = 32;

    // Reset value of the active frame count register.
    localparam logic [CFG_W-1:0] FRAMES_RST = 5'd16;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FREE,
        ST_SWEEP
    } state_t;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic rehome;     // move the hand token back to cell 0
        logic step;       // pass the hand token to the next cell
        logic clear_ref;  // clear the reference bit under the hand
        logic write;      // store the key in the frame under the hand
        logic hit;        // set the reference bit of the first matching frame
    } cell_cmd_t;

    // Summary of the cell row seen by the sequencer.
    typedef struct packed {
        logic              any_hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              all_valid;
        logic              tok_valid;
        logic              tok_ref;
        logic              tok_beyond;
        logic [SLOT_W-1:0] tok_slot;
    } row_status_t;

endpackage

>>> hdl/cpr_cell.sv
// One page frame of the clock replacement row: page, valid and reference bits,
// and its share of the one-hot clock hand. Depends on cpr_pkg.
module cpr_cell #(
    parameter int         PAGE_BITS = cpr_pkg::PAGE_BITS_DEF,
    parameter logic       FIRST     = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cpr_pkg::cell_cmd_t    cmd,
    input  logic                  hit_first,
    input  logic [PAGE_BITS-1:0]  key,
    input  logic                  active,
    input  logic                  last,
    input  logic                  tok_in,
    output logic                  match,
    output logic                  tok,
    output logic                  valid,
    output logic                  refb,
    output logic [PAGE_BITS-1:0]  page,
    output logic                  tok_out,
    output logic                  wrap_out
);

    logic                 valid_reg, valid_next;
    logic                 ref_reg, ref_next;
    logic                 tok_reg, tok_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 write_here;

    // A write lands only in the frame that holds the hand.
    assign write_here = cmd.write && tok_reg;

    // Next values of the flag bits and of the hand token.
    always_comb
    begin
        valid_next = valid_reg || write_here;
        if (write_here)
        begin
            ref_next = 1'b1;
        end
        else if (cmd.clear_ref && tok_reg)
        begin
            ref_next = 1'b0;
        end
        else if (cmd.hit && hit_first)
        begin
            ref_next = 1'b1;
        end
        else
        begin
            ref_next = ref_reg;
        end
        if (cmd.rehome)
        begin
            tok_next = FIRST;
        end
        else if (cmd.step)
        begin
            tok_next = tok_in;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    // Control bits of the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ref_reg   <= 1'b0;
            tok_reg   <= FIRST;
        end
        else
        begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
            tok_reg   <= tok_next;
        end
    end

    // Stored page number; meaningful only once the frame is valid.
    always_ff @(posedge clk)
    begin
        if (write_here)
        begin
            page_reg <= key;
        end
    end

    // Local compare and hand transfer to the neighbour.
    assign match    = valid_reg && active && (page_reg == key);
    assign tok      = tok_reg;
    assign valid    = valid_reg;
    assign refb     = ref_reg;
    assign page     = page_reg;
    assign tok_out  = tok_reg && !last;
    assign wrap_out = tok_reg && last;

endmodule

>>> hdl/cpr_ctrl.sv
// Sequencer of the clock replacement block: input and output transfers,
// the hand walk over the cell row and the fault counter. Depends on cpr_pkg.
module cpr_ctrl #(
    parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cpr_pkg::PAGE_W-1:0]    page_number,
    output logic [PAGE_BITS-1:0]          key,
    input  cpr_pkg::row_status_t          status,
    input  logic [PAGE_BITS-1:0]          tok_page,
    output cpr_pkg::cell_cmd_t            cmd,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [cpr_pkg::SLOT_W-1:0]    frame_slot,
    output logic                          evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]    evicted_page,
    output logic [cpr_pkg::COUNT_W-1:0]   fault_count
);

    cpr_pkg::state_t               state_reg, state_next;
    logic [PAGE_BITS-1:0]          key_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          hit_reg;
    logic [cpr_pkg::SLOT_W-1:0]    slot_reg;
    logic                          ev_valid_reg;
    logic [cpr_pkg::PAGE_W-1:0]    ev_page_reg;
    logic [cpr_pkg::COUNT_W-1:0]   fault_reg, fault_next;
    logic                          out_free;
    logic                          accept;
    logic                          finish;
    logic                          res_hit;
    logic                          res_evict;
    logic [cpr_pkg::SLOT_W-1:0]    res_slot;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = (state_reg == cpr_pkg::ST_IDLE) && in_valid;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cpr_pkg::ST_LOOK;
                end
            end
            cpr_pkg::ST_LOOK:
            begin
                if (status.any_hit)
                begin
                    if (out_free)
                    begin
                        state_next = cpr_pkg::ST_IDLE;
                    end
                end
                else if (!status.all_valid)
                begin
                    state_next = cpr_pkg::ST_FREE;
                end
                else
                begin
                    state_next = cpr_pkg::ST_SWEEP;
                end
            end
            cpr_pkg::ST_FREE:
            begin
                if (!status.tok_valid && out_free)
                begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            cpr_pkg::ST_SWEEP:
            begin
                if (!status.tok_ref && out_free)
                begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the row and result selection.
    always_comb
    begin
        cmd       = '0;
        finish    = 1'b0;
        res_hit   = 1'b0;
        res_evict = 1'b0;
        res_slot  = status.tok_slot;
        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                cmd.rehome = accept && status.tok_beyond;
            end
            cpr_pkg::ST_LOOK:
            begin
                if (status.any_hit && out_free)
                begin
                    cmd.hit  = 1'b1;
                    finish   = 1'b1;
                    res_hit  = 1'b1;
                    res_slot = status.hit_slot;
                end
            end
            cpr_pkg::ST_FREE:
            begin
                if (status.tok_valid)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.write = 1'b1;
                    cmd.step  = 1'b1;
                    finish    = 1'b1;
                end
            end
            cpr_pkg::ST_SWEEP:
            begin
                if (status.tok_ref)
                begin
                    cmd.clear_ref = 1'b1;
                    cmd.step      = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.write = 1'b1;
                    cmd.step  = 1'b1;
                    finish    = 1'b1;
                    res_evict = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output register and saturating fault counter.
    always_comb
    begin
        out_valid_next = finish || (out_valid_reg && out_stall);
        fault_next     = fault_reg;
        if (finish && !res_hit && (fault_reg != '1))
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
        end
    end

    // Key and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= PAGE_BITS'(page_number);
        end
        if (finish)
        begin
            hit_reg      <= res_hit;
            slot_reg     <= res_slot;
            ev_valid_reg <= res_evict;
            ev_page_reg  <= res_evict ? cpr_pkg::PAGE_W'(tok_page) : '0;
        end
    end

    assign in_stall      = (state_reg != cpr_pkg::ST_IDLE);
    assign key           = key_reg;
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_reg;

    // The fault total never goes backwards.
    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fault_reg >= $past(fault_reg)))
        else $error("fault total decreased");

    // A hit never reports a replaced page.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && ev_valid_reg))
        else $error("hit result carries an eviction");

    // A fault result always follows at least one counted fault.
    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (fault_reg != '0))
        else $error("fault result with zero fault total");

    // A write into the row only ever happens when a result is produced.
    a_write_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> out_valid_reg)
        else $error("frame written without a result");

endmodule

>>> hdl/clock_page_replacement.sv
// Clock (second chance) page replacement over a row of frame cells, with its
// sequencer. Depends on cpr_pkg, cpr_cell and cpr_ctrl.
//
// Each page reference is compared against all active frames at once. A hit
// is found in the look state and its result is registered. On a miss the
// clock hand, a one-hot token passed from cell to cell, walks one frame per
// cycle: a fill writes the first free frame that the hand reaches; a
// replacement clears the set reference bits that the hand passes, at most the
// active frame count of them, and writes the first frame whose reference bit
// is clear. The input is stalled from a transfer until that reference has
// produced its result, so a new reference is taken only once the last one has
// finished. A finished result waits in the output register and does not hold
// up the next transfer, but the following result cannot finish until it has
// gone. The active frame count is written through the configuration channel,
// which is always ready; 0 acts as 1 and values above MAX_FRAMES act as
// MAX_FRAMES.
module clock_page_replacement #(
    parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cpr_pkg::PAGE_W-1:0]    page_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [cpr_pkg::SLOT_W-1:0]    frame_slot,
    output logic                          evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]    evicted_page,
    output logic [cpr_pkg::COUNT_W-1:0]   fault_count
);

    localparam int NW = $clog2(MAX_FRAMES + 1);

    logic [cpr_pkg::CFG_W-1:0] frames_reg;
    logic [NW-1:0]             n_eff;
    logic [PAGE_BITS-1:0]      key;
    cpr_pkg::cell_cmd_t        cmd;
    cpr_pkg::row_status_t      status;
    logic [PAGE_BITS-1:0]      tok_page;

    logic [MAX_FRAMES-1:0]     active;
    logic [MAX_FRAMES-1:0]     last;
    logic [MAX_FRAMES-1:0]     match;
    logic [MAX_FRAMES-1:0]     hit_first;
    logic [MAX_FRAMES-1:0]     tok;
    logic [MAX_FRAMES-1:0]     valid;
    logic [MAX_FRAMES-1:0]     refb;
    logic [MAX_FRAMES-1:0]     tok_in;
    logic [MAX_FRAMES-1:0]     tok_out;
    logic [MAX_FRAMES-1:0]     wrap_out;
    logic [PAGE_BITS-1:0]      page [MAX_FRAMES];

    // Frame count register; a transfer is taken in every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= cpr_pkg::FRAMES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Active frame count clamped to the built range.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(frames_reg) > MAX_FRAMES)
        begin
            n_eff = NW'(MAX_FRAMES);
        end
        else
        begin
            n_eff = NW'(frames_reg);
        end
    end

    // The row of frame cells; the hand token wraps from the last active cell.
    for (genvar i = 0; i < MAX_FRAMES; i++)
    begin : g_cell
        assign active[i] = (n_eff > NW'(i));
        assign last[i]   = (n_eff == NW'(i + 1));
        if (i == 0)
        begin : g_head
            assign tok_in[i] = |wrap_out;
        end
        else
        begin : g_body
            assign tok_in[i] = tok_out[i-1];
        end

        cpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .FIRST     ((i == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .hit_first (hit_first[i]),
            .key       (key),
            .active    (active[i]),
            .last      (last[i]),
            .tok_in    (tok_in[i]),
            .match     (match[i]),
            .tok       (tok[i]),
            .valid     (valid[i]),
            .refb      (refb[i]),
            .page      (page[i]),
            .tok_out   (tok_out[i]),
            .wrap_out  (wrap_out[i])
        );
    end

    // Lowest matching frame wins.
    assign hit_first = match & (~match + 1'b1);

    // Row summary: encoded slots, flags under the hand and the page it holds.
    always_comb
    begin
        status            = '0;
        tok_page          = '0;
        status.any_hit    = |match;
        status.all_valid  = &(valid | ~active);
        status.tok_valid  = |(tok & valid);
        status.tok_ref    = |(tok & refb);
        status.tok_beyond = |(tok & ~active);
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (hit_first[i])
            begin
                status.hit_slot = status.hit_slot | cpr_pkg::SLOT_W'(i);
            end
            if (tok[i])
            begin
                status.tok_slot = status.tok_slot | cpr_pkg::SLOT_W'(i);
                tok_page        = tok_page | page[i];
            end
        end
    end

    cpr_ctrl #(
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .key           (key),
        .status        (status),
        .tok_page      (tok_page),
        .cmd           (cmd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    // Exactly one cell holds the hand at all times.
    a_hand_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(tok))
        else $error("clock hand token lost or duplicated");

endmodule

>>> test/tb_clock_page_replacement.sv
`timescale 1ns / 100ps
// Self-checking testbench for clock_page_replacement: directed and random page references.
// Depends on cpr_pkg and clock_page_replacement; needs no files or arguments.
module tb_clock_page_replacement;

    localparam int FRAMES = cpr_pkg::MAX_FRAMES_DEF;
    localparam int SETTLE_CYCLES = 2 * FRAMES + 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1700;

    // One result transfer as the block reports it.
    typedef struct packed {
        logic                        hit;
        logic [cpr_pkg::SLOT_W-1:0]  slot;
        logic                        ev_valid;
        logic [cpr_pkg::PAGE_W-1:0]  ev_page;
        logic [cpr_pkg::COUNT_W-1:0] faults;
    } page_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [cpr_pkg::CFG_W-1:0]    cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [cpr_pkg::PAGE_W-1:0]   page_number;
    logic                         out_valid;
    logic                         out_stall;
    logic                         hit;
    logic [cpr_pkg::SLOT_W-1:0]   frame_slot;
    logic                         evicted_valid;
    logic [cpr_pkg::PAGE_W-1:0]   evicted_page;
    logic [cpr_pkg::COUNT_W-1:0]  fault_count;

    // Predictor state: a private copy of the frame table and clock hand.
    logic [cpr_pkg::PAGE_W-1:0]   frame_tag [FRAMES];
    logic                         frame_live [FRAMES];
    logic                         frame_used [FRAMES];
    int unsigned                  clock_hand;
    logic [cpr_pkg::COUNT_W-1:0]  fault_tally;
    logic [cpr_pkg::CFG_W-1:0]    frames_setting;

    page_result_t        pending_results[$];
    int                  mismatches;
    int                  refs_sent;
    int                  hits_seen;
    int                  evictions_seen;
    int                  cfg_writes;
    int                  results_checked;
    bit                  steady_flow;
    int                  hold_requests;

    clock_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: ends a hung run.
    initial
    begin
        #10_000_000;
        $display("tb_clock_page_replacement: done, errors");
        $finish;
    end

    // Effective frame count: zero acts as one, oversize values are clamped.
    function automatic int unsigned active_count(
        input logic [cpr_pkg::CFG_W-1:0] setting
    );
        if (setting == '0)
            return 1;
        if (setting > FRAMES)
            return FRAMES;
        return setting;
    endfunction

    function automatic int unsigned next_frame(input int unsigned pos, input int unsigned n);
        return (pos + 1 >= n) ? 0 : pos + 1;
    endfunction

    // Second chance replacement for one page reference; returns the expected result.
    function automatic page_result_t replace_page(input logic [cpr_pkg::PAGE_W-1:0] pg);
        page_result_t res;
        int unsigned  n;
        int unsigned  pos;
        bit           found;
        bit           have_free;
        bit           swept;
        n = active_count(frames_setting);
        res = '0;
        found = 1'b0;
        have_free = 1'b0;
        swept = 1'b0;
        if (clock_hand >= n)
            clock_hand = 0;

        // Lowest matching active frame wins.
        for (int i = 0; i < n; i++)
        begin
            if (!found && frame_live[i] && frame_tag[i] == pg)
            begin
                found = 1'b1;
                res.slot = cpr_pkg::SLOT_W'(i);
            end
        end

        if (found)
        begin
            frame_used[res.slot] = 1'b1;
            res.hit = 1'b1;
        end
        else
        begin
            // First free active frame at or after the hand, wrapping round.
            pos = clock_hand;
            for (int i = 0; i < n; i++)
            begin
                if (!have_free)
                begin
                    if (!frame_live[pos])
                        have_free = 1'b1;
                    else
                        pos = next_frame(pos, n);
                end
            end
            // All full: clear set reference bits until a clear one turns up.
            if (!have_free)
            begin
                pos = clock_hand;
                for (int i = 0; i <= n; i++)
                begin
                    if (!swept)
                    begin
                        if (!frame_used[pos])
                            swept = 1'b1;
                        else
                        begin
                            frame_used[pos] = 1'b0;
                            pos = next_frame(pos, n);
                        end
                    end
                end
                res.ev_valid = 1'b1;
                res.ev_page = frame_tag[pos];
            end
            res.slot = cpr_pkg::SLOT_W'(pos);
            frame_tag[pos] = pg;
            frame_live[pos] = 1'b1;
            frame_used[pos] = 1'b1;
            clock_hand = next_frame(pos, n);
            if (fault_tally != '1)
                fault_tally = fault_tally + 1'b1;
        end
        res.faults = fault_tally;
        return res;
    endfunction

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one page reference and wait for its transfer. Entered and left at a falling edge.
    task automatic send_page(input logic [cpr_pkg::PAGE_W-1:0] pg);
        int gap;
        page_result_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        page_number <= pg;
        do
            @(posedge clk);
        while (in_stall);
        want = replace_page(pg);
        pending_results = {pending_results, want};
        refs_sent++;
        if (want.hit)
            hits_seen++;
        if (want.ev_valid)
            evictions_seen++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result has arrived and the block is quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the active frame count while the block is idle.
    task automatic write_frame_count(input logic [cpr_pkg::CFG_W-1:0] setting);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= setting;
        do
            @(posedge clk);
        while (!cfg_ready);
        frames_setting = setting;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Page numbers at both extremes, a fill and hits on them.
    task automatic test_extremes();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
    endtask

    // A frame count of zero acts as a single frame: every miss replaces it.
    task automatic test_single_frame();
        write_frame_count(5'd0);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'h5678);
    endtask

    // Counts above the built size act as the full table.
    task automatic test_oversized_count();
        write_frame_count(5'd31);
        send_page(16'hFFFF);
        send_page(16'hABCD);
    endtask

    // Shrinking leaves stale copies that show up again as duplicates, and the free
    // frame found on a miss need not be the one at the hand. Shrinking below the
    // hand position sends the hand back to frame zero.
    task automatic test_duplicate_pages();
        write_frame_count(5'd2);
        send_page(16'hABCD);
        write_frame_count(5'd16);
        send_page(16'hABCD);
        send_page(16'h7777);
        write_frame_count(5'd3);
        send_page(16'h0F0F);
    endtask

    // A full small table: hits grant a second chance and the sweep clears them.
    task automatic test_second_chance_sweep();
        send_page(16'h000A);
        send_page(16'h000B);
        send_page(16'h000C);
        send_page(16'h000A);
        send_page(16'h000D);
        send_page(16'h000E);
    endtask

    // The receiver holds off for a long stretch while references keep coming,
    // so the block fills up and stalls its input.
    task automatic test_backpressure();
        write_frame_count(5'd8);
        steady_flow = 1'b1;
        hold_requests++;
        repeat (30) send_page(16'($urandom_range(0, 11)));
        steady_flow = 1'b0;
        wait_drained();
    endtask

    // Phases of references with locality over a working set, plus random noise,
    // each under its own frame count; state carries over between phases.
    task automatic test_random_traffic();
        logic [cpr_pkg::PAGE_W-1:0] pool [34];
        logic [cpr_pkg::CFG_W-1:0]  setting;
        int                         phase;
        int                         pool_len;
        int                         count;
        int                         target;
        phase = 0;
        target = refs_sent + RANDOM_ITEMS;
        while (refs_sent < target)
        begin
            case (phase)
                0: setting = 5'd1;
                1: setting = 5'd16;
                2: setting = 5'd0;
                3: setting = 5'd31;
                default: setting = cpr_pkg::CFG_W'($urandom_range(0, 31));
            endcase
            write_frame_count(setting);
            steady_flow = ($urandom_range(0, 5) == 0);
            pool_len = $urandom_range(active_count(setting) / 2 + 1,
                                      2 * active_count(setting) + 2);
            for (int i = 0; i < pool_len; i++)
                pool[i] = cpr_pkg::PAGE_W'($urandom);
            count = $urandom_range(60, 140);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_page(cpr_pkg::PAGE_W'($urandom));
                else
                    send_page(pool[$urandom_range(0, pool_len - 1)]);
            end
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: random stalls, plus the long hold when one is asked for.
    initial
    begin
        int holds_served;
        int hold_left;
        int stall_left;
        holds_served = 0;
        hold_left = 0;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!steady_flow && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Checker: each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        page_result_t got;
        page_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{hit, frame_slot, evicted_valid, evicted_page, fault_count};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result hit=%0b slot=%0d evicted=%0b/%h faults=%0d",
                             $realtime, got.hit, got.slot, got.ev_valid, got.ev_page,
                             got.faults);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch: expected hit=%0b slot=%0d evicted=%0b/%h ",
                                  "faults=%0d, got hit=%0b slot=%0d evicted=%0b/%h faults=%0d"},
                                 $realtime, want.hit, want.slot, want.ev_valid, want.ev_page,
                                 want.faults, got.hit, got.slot, got.ev_valid, got.ev_page,
                                 got.faults);
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        page_number = '0;
        steady_flow = 1'b0;
        hold_requests = 0;
        mismatches = 0;
        refs_sent = 0;
        hits_seen = 0;
        evictions_seen = 0;
        cfg_writes = 0;
        results_checked = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_tag[i] = '0;
            frame_live[i] = 1'b0;
            frame_used[i] = 1'b0;
        end
        clock_hand = 0;
        fault_tally = '0;
        frames_setting = cpr_pkg::FRAMES_RST;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_single_frame();
        test_oversized_count();
        test_duplicate_pages();
        test_second_chance_sweep();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (pending_results.size() != 0)
            mismatches += pending_results.size();
        $display("Covered %0d page references (%0d hits, %0d evictions), %0d results checked,",
                 refs_sent, hits_seen, evictions_seen, results_checked);
        $display("%0d frame count writes including zero and oversize, and a long output hold.",
                 cfg_writes);
        if (mismatches == 0)
            $display("tb_clock_page_replacement: done, clean");
        else
            $display("tb_clock_page_replacement: done, errors");
        $finish;
    end

endmodule
